FILE: rtl/spjq_pkg.sv
// Shared types and constants of the sorted priority job queue.
package spjq_pkg;

    localparam int DEPTH_DEFAULT     = 16;
    localparam int KEY_WIDTH_DEFAULT = 16;

    localparam int FIELD_WIDTH = 16;
    localparam int OCC_WIDTH   = 5;
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 40;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Result item, first member in the highest bits.
    typedef struct packed {
        logic [OCC_WIDTH-1:0]   occupancy;
        status_t                status;
        logic [FIELD_WIDTH-1:0] tag;
        logic [FIELD_WIDTH-1:0] key;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_PLACE = 5'b00100,
        S_FETCH = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

endpackage

FILE: rtl/sorted_priority_job_queue_core.sv
// Sorted priority job queue: one memory of key/tag entries kept in descending key order.
//
// Usage: each input item on the s_ channel is a request. s_tuser selects an
// insert (0) or a remove (1); s_tdata carries the job key and tag of an insert.
// Every request returns exactly one result item on the m_ channel with the
// removed key and tag (zero when nothing was removed), a status code and the
// occupancy after the request. An insert on a full queue and a remove on an
// empty queue leave the queue unchanged and are flagged in the status.
// An insert walks the memory from the tail toward the head, one entry per
// cycle, moving each entry with a key not above the new key down by one place
// through the single read port and single write port. The registered memory
// read paces the walk. The block works on one request at a time; it accepts
// the next request as soon as the previous result has been moved into the
// output register, even if the receiver has not yet taken it. A stalled
// receiver holds the result in that register, and a further result waits in
// the done state until it frees. Reset empties the queue at once; the memory
// itself is not cleared because only entries below the occupancy count are
// ever read.
module sorted_priority_job_queue_core
    import spjq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // job_key [15:0], job_tag [31:16]
    input  logic                s_tuser,   // req_type [0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // out_key [15:0], out_tag [31:16],
                                           // status [33:32], occupancy [38:34], zero [39]
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [KEY_WIDTH-1:0]   key;
        logic [FIELD_WIDTH-1:0] tag;
    } entry_t;

    // Entry storage: one write port, one read port with registered data.
    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic           out_valid_reg, out_valid_next;
    entry_t         job_reg;
    result_t        res_reg, res_next;
    result_t        out_reg;

    logic           accept;
    logic           res_load;
    logic           out_load;
    entry_t         in_entry;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    entry_t         wr_data;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // The key keeps only its low KEY_WIDTH bits.
    assign in_entry.key = KEY_WIDTH'(s_tdata[FIELD_WIDTH-1:0]);
    assign in_entry.tag = s_tdata[2*FIELD_WIDTH-1:FIELD_WIDTH];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = job_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg - AW'(1);
        res_load   = 1'b0;
        res_next   = '0;
        out_load   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == REQ_REMOVE)
                    begin
                        if (count_reg == '0)
                        begin
                            res_load        = 1'b1;
                            res_next.status = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            // The tail entry holds the smallest key.
                            rd_en      = 1'b1;
                            rd_addr    = AW'(count_reg - CW'(1));
                            count_next = count_reg - CW'(1);
                            state_next = S_FETCH;
                        end
                    end
                    else if (count_reg == CW'(DEPTH))
                    begin
                        res_load           = 1'b1;
                        res_next.status    = ST_FULL;
                        res_next.occupancy = OCC_WIDTH'(count_reg);
                        state_next         = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        wr_en              = 1'b1;
                        wr_addr            = '0;
                        wr_data            = in_entry;
                        count_next         = CW'(1);
                        res_load           = 1'b1;
                        res_next.status    = ST_OK;
                        res_next.occupancy = OCC_WIDTH'(1);
                        state_next         = S_DONE;
                    end
                    else
                    begin
                        // Start the walk at the tail: read the last entry,
                        // the free slot just below it is the first write.
                        rd_en      = 1'b1;
                        rd_addr    = AW'(count_reg - CW'(1));
                        idx_next   = AW'(count_reg);
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                wr_en = 1'b1;
                if (rd_data_reg.key > job_reg.key)
                begin
                    // Larger keys stay; the new job lands in the open slot.
                    count_next         = count_reg + CW'(1);
                    res_load           = 1'b1;
                    res_next.status    = ST_OK;
                    res_next.occupancy = OCC_WIDTH'(count_reg + CW'(1));
                    state_next         = S_DONE;
                end
                else
                begin
                    // Equal or smaller key moves down, so a new job goes
                    // ahead of older jobs with the same key.
                    wr_data  = rd_data_reg;
                    idx_next = idx_reg - AW'(1);
                    if (idx_reg == AW'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = idx_reg - AW'(2);
                    end
                end
            end

            S_PLACE:
            begin
                wr_en              = 1'b1;
                count_next         = count_reg + CW'(1);
                res_load           = 1'b1;
                res_next.status    = ST_OK;
                res_next.occupancy = OCC_WIDTH'(count_reg + CW'(1));
                state_next         = S_DONE;
            end

            S_FETCH:
            begin
                res_load           = 1'b1;
                res_next.key       = FIELD_WIDTH'(rd_data_reg.key);
                res_next.tag       = rd_data_reg.tag;
                res_next.status    = ST_OK;
                res_next.occupancy = OCC_WIDTH'(count_reg);
                state_next         = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= in_entry;
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The occupancy never exceeds the number of memory entries.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("occupancy count above depth");

    // Writes never land beyond the slot just below the current tail.
    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (CW'(wr_addr) <= count_reg))
        else $error("memory write outside the occupied range");

    // A remove on a non-empty queue drops the count by exactly one.
    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == REQ_REMOVE && count_reg != '0)
            |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("remove did not decrement the occupancy");

    // The walk only runs on a queue that is neither empty nor full.
    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (count_reg != '0 && count_reg < CW'(DEPTH)
            && CW'(idx_reg) <= count_reg))
        else $error("insert walk with an invalid occupancy");

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the sorted priority job queue core.
`timescale 1ns / 100ps

module tb_top;
    import spjq_pkg::*;

    localparam int QDEPTH        = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS  = 1430;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 30;
    localparam logic [FIELD_WIDTH-1:0] KEY_MASK =
        FIELD_WIDTH'((64'd1 << KEY_WIDTH_DEFAULT) - 1);

    // One row of the directed table. When typed is set, want holds a result
    // that is obvious from the request alone and is used instead of the
    // predicted one.
    typedef struct {
        logic                   req;
        logic [FIELD_WIDTH-1:0] key;
        logic [FIELD_WIDTH-1:0] tag;
        bit                     typed;
        result_t                want;
    } probe_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Our own copy of the queue, kept in descending key order.
    logic [FIELD_WIDTH-1:0] held_keys [QDEPTH];
    logic [FIELD_WIDTH-1:0] held_tags [QDEPTH];
    int                     held_count = 0;

    result_t    pending_results [$];
    probe_row_t probe_rows [$];
    int         err_count = 0;
    int         quiet_cycles = 0;
    int         rx_hold = 0;
    bit         tx_calm = 1'b0;
    bit         rx_calm = 1'b0;

    sorted_priority_job_queue_core #(
        .DEPTH     (QDEPTH),
        .KEY_WIDTH (KEY_WIDTH_DEFAULT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    // Apply one request to the local queue and return the result it causes.
    function automatic result_t schedule_request(input logic req,
                                                 input logic [FIELD_WIDTH-1:0] key,
                                                 input logic [FIELD_WIDTH-1:0] tag);
        result_t                r;
        int                     pos;
        logic [FIELD_WIDTH-1:0] k;
        r        = '0;
        r.status = ST_OK;
        k        = key & KEY_MASK;
        if (req == REQ_INSERT) begin
            if (held_count >= QDEPTH) begin
                r.status = ST_FULL;
            end
            else begin
                // A new job goes ahead of any older job with the same key.
                pos = 0;
                while (pos < held_count && held_keys[pos] > k)
                    pos++;
                for (int i = held_count; i > pos; i--) begin
                    held_keys[i] = held_keys[i-1];
                    held_tags[i] = held_tags[i-1];
                end
                held_keys[pos] = k;
                held_tags[pos] = tag;
                held_count++;
            end
        end
        else if (held_count == 0) begin
            r.status = ST_EMPTY;
        end
        else begin
            held_count--;
            r.key = held_keys[held_count];
            r.tag = held_tags[held_count];
        end
        r.occupancy = OCC_WIDTH'(held_count);
        return r;
    endfunction

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 48);
    endfunction

    // Narrow keys pile up equal values so the first-in, first-out order
    // among them gets exercised.
    function automatic logic [FIELD_WIDTH-1:0] pick_key(input bit narrow);
        int r;
        r = $urandom_range(0, 99);
        if (narrow || r < 25)
            return FIELD_WIDTH'($urandom_range(0, 7));
        else if (r < 30)
            return '0;
        else if (r < 35)
            return '1;
        return FIELD_WIDTH'($urandom());
    endfunction

    task automatic add_row(input logic req, input logic [FIELD_WIDTH-1:0] key,
                           input logic [FIELD_WIDTH-1:0] tag, input bit typed,
                           input status_t st, input int occ,
                           input logic [FIELD_WIDTH-1:0] okey,
                           input logic [FIELD_WIDTH-1:0] otag);
        probe_row_t row;
        row.req            = req;
        row.key            = key;
        row.tag            = tag;
        row.typed          = typed;
        row.want.key       = okey;
        row.want.tag       = otag;
        row.want.status    = st;
        row.want.occupancy = OCC_WIDTH'(occ);
        probe_rows.push_back(row);
    endtask

    // Present one request after an optional gap and wait until it is taken.
    task automatic send_request(input logic req, input logic [FIELD_WIDTH-1:0] key,
                                input logic [FIELD_WIDTH-1:0] tag, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {tag, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic note_mismatch(input string what, input logic [M_DATA_W-1:0] want_v,
                                 input logic [M_DATA_W-1:0] got_v);
        err_count++;
        if (err_count <= 10)
            $display("tb_top: mismatch on %s: expected %h, got %h", what, want_v, got_v);
    endtask

    // Receiver side: random back-pressure, switched off in calm stretches.
    always @(posedge clk) begin
        if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end
        else begin
            m_tready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 99) < 20)
                rx_hold <= pick_gap() + 1;
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk) begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[M_DATA_W-2:0]);
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", '0, m_tdata);
            end
            else begin
                want = pending_results.pop_front();
                if (got.key !== want.key)
                    note_mismatch("out_key", M_DATA_W'(want.key), M_DATA_W'(got.key));
                if (got.tag !== want.tag)
                    note_mismatch("out_tag", M_DATA_W'(want.tag), M_DATA_W'(got.tag));
                if (got.status !== want.status)
                    note_mismatch("status", M_DATA_W'(want.status), M_DATA_W'(got.status));
                if (got.occupancy !== want.occupancy)
                    note_mismatch("occupancy", M_DATA_W'(want.occupancy),
                                  M_DATA_W'(got.occupancy));
                if (m_tdata[M_DATA_W-1] !== 1'b0)
                    note_mismatch("pad bit", '0, M_DATA_W'(m_tdata[M_DATA_W-1]));
            end
        end
    end

    // Watchdog: too long without any item moving on either side ends the run.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        probe_row_t row;
        result_t    pred;
        int         sent;
        int         phase_len;
        int         mode;
        int         insert_pct;
        logic       req;
        logic [FIELD_WIDTH-1:0] key;

        // Directed part: empty queue, key extremes, equal keys, full queue.
        add_row(REQ_REMOVE, 16'h1234, 16'h5678, 1'b1, ST_EMPTY, 0, '0, '0);
        add_row(REQ_INSERT, 16'hFFFF, 16'hFFFF, 1'b1, ST_OK, 1, '0, '0);
        add_row(REQ_INSERT, 16'h0000, 16'h0000, 1'b1, ST_OK, 2, '0, '0);
        add_row(REQ_INSERT, 16'h8000, 16'h1234, 1'b0, ST_OK, 0, '0, '0);
        add_row(REQ_INSERT, 16'h8000, 16'h5678, 1'b0, ST_OK, 0, '0, '0);
        for (int i = 1; i <= QDEPTH - 4; i++)
            add_row(REQ_INSERT, FIELD_WIDTH'(i * 16'h1111), FIELD_WIDTH'(16'hA000 + i),
                    1'b0, ST_OK, 0, '0, '0);
        add_row(REQ_INSERT, 16'h4321, 16'hBEEF, 1'b1, ST_FULL, QDEPTH, '0, '0);
        // The smallest key is the zero inserted above.
        add_row(REQ_REMOVE, 16'hFFFF, 16'hFFFF, 1'b1, ST_OK, QDEPTH - 1, '0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probe_rows[i]) begin
            row = probe_rows[i];
            send_request(row.req, row.key, row.tag, pick_gap());
            pred = schedule_request(row.req, row.key, row.tag);
            pending_results.push_back(row.typed ? row.want : pred);
        end
        drain_results();

        // Random part in phases that lean toward filling, draining, a
        // balanced mix, or a few repeated keys.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(30, 110);
            mode      = $urandom_range(0, 3);
            tx_calm   = ($urandom_range(0, 3) == 0);
            rx_calm   = ($urandom_range(0, 3) == 0);
            case (mode)
                0:       insert_pct = 80;
                1:       insert_pct = 20;
                2:       insert_pct = 50;
                default: insert_pct = 55;
            endcase
            for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
                req = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
                key = pick_key(mode == 3);
                send_request(req, key, FIELD_WIDTH'($urandom()), tx_calm ? 0 : pick_gap());
                pending_results.push_back(schedule_request(req, key, s_tdata[31:16]));
                sent++;
            end
            if ($urandom_range(0, 2) == 0)
                drain_results();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

FILE: sorted_priority_job_queue_core.f
rtl/spjq_pkg.sv
rtl/sorted_priority_job_queue_core.sv
bench/tb_top.sv
